@@ design/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define MPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every edge including reset
`define MPA_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ design/mpa_pkg.sv @@
// Shared types and constants of the max pooling unit
package mpa_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int INDEX_W     = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int OUTQ_DEPTH  = 3;
   localparam int OUTQ_PTR_W  = 2;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 512;
   localparam int DEF_MAX_MAPS   = 64;
   localparam int DEF_MAX_WINDOW = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_WIDTH  = 3'd0,
      CSR_WINDOW_HEIGHT = 3'd1,
      CSR_INPUT_WIDTH   = 3'd2,
      CSR_INPUT_HEIGHT  = 3'd3,
      CSR_MAP_COUNT     = 3'd4
   } mpa_csr_type;

   // Per-sample control carried from the counters to the store update
   typedef struct packed {
      logic                       active;
      logic                       first;
      logic                       emit;
      logic                       last;
      logic signed [SAMPLE_W-1:0] sample;
      logic [INDEX_W-1:0]         src_index;
      logic [INDEX_W-1:0]         out_index;
   } mpa_tag_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic [INDEX_W-1:0]         index;
   } mpa_entry_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] max_value;
      logic [INDEX_W-1:0]         source_index;
      logic [INDEX_W-1:0]         out_index;
      logic                       frame_last;
   } mpa_result_type;

endpackage

@@ design/mpa_if.sv @@
// Stream channel interfaces: sample requests and pooled responses
interface mpa_req_if import mpa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface mpa_rsp_if import mpa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] max_value;
   logic [INDEX_W-1:0]         source_index;
   logic [INDEX_W-1:0]         out_index;
   logic                       frame_last;

   modport source (output valid, output max_value, output source_index,
                   output out_index, output frame_last, input ready);
   modport sink (input valid, input max_value, input source_index,
                 input out_index, input frame_last, output ready);
endinterface

@@ design/max_pool_with_argmax_unit.sv @@
// Non-overlapping max pooling with argmax over a raster sample stream.
// The unit takes one sample per clock while the request side is not stalled:
// each beat reads its window column's partial maximum from a row buffer
// (one entry per window column, MAX_WIDTH entries) in the cycle it is
// accepted, compares and writes it back in the next, and a finished window's
// result goes from the update stage into the result queue and on to the response channel.
// A three-beat result queue lets samples keep flowing while the response side
// stalls; the request side stalls only once that queue holds, or is about to
// hold, three beats. Writing any register restarts the frame counters, and
// registers are to be written only while no beat is in flight. The row buffer
// needs no clearing after reset.
module max_pool_with_argmax_unit import mpa_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_MAPS   = DEF_MAX_MAPS,
   parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   mpa_req_if.sink                req_ch,
   mpa_rsp_if.source              rsp_ch
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic           accept;
   logic           space;
   logic [AW-1:0]  rd_addr;
   mpa_tag_type    tag;
   logic           push;
   mpa_result_type push_data;

   assign req_ch.ready = space;
   assign accept       = req_ch.valid && space;

   mpa_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_MAPS   (MAX_MAPS),
      .MAX_WINDOW (MAX_WINDOW),
      .AW         (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .sample    (req_ch.sample),
      .rd_addr   (rd_addr),
      .tag       (tag)
   );

   mpa_update #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rd_addr   (rd_addr),
      .tag       (tag),
      .push      (push),
      .push_data (push_data)
   );

   mpa_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .space     (space),
      .rsp_ch    (rsp_ch)
   );

endmodule

@@ design/mpa_ctrl.sv @@
// Configuration registers and raster position counters
module mpa_ctrl import mpa_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_MAPS   = DEF_MAX_MAPS,
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   input  logic                         accept,
   input  logic signed [SAMPLE_W-1:0]   sample,
   output logic [AW-1:0]                rd_addr,
   output mpa_tag_type                  tag
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int MW = $clog2(MAX_MAPS + 1);
   localparam int WB = $clog2(MAX_WINDOW + 1);
   localparam int SW = ((CW > WB) ? CW : WB) + 2;
   localparam int SH = ((RW > WB) ? RW : WB) + 2;

   localparam int WW_RST = (MAX_WINDOW < 2) ? MAX_WINDOW : 2;
   localparam int IW_RST = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
   localparam int IH_RST = (MAX_HEIGHT < 32) ? MAX_HEIGHT : 32;

   logic [WB-1:0] ww_ff, ww_in, wh_ff, wh_in;
   logic [CW-1:0] iw_ff, iw_in;
   logic [RW-1:0] ih_ff, ih_in;
   logic [MW-1:0] maps_ff, maps_in;
   logic          restart;

   logic [CW-1:0]      col_ff, col_in, col_start_ff, col_start_in;
   logic [WB-1:0]      ciw_ff, ciw_in, riw_ff, riw_in;
   logic [AW-1:0]      wc_ff, wc_in;
   logic [RW-1:0]      row_ff, row_in, row_start_ff, row_start_in;
   logic [MW-1:0]      map_ff, map_in;
   logic [INDEX_W-1:0] src_ff, src_in, out_ff, out_in;

   logic [SW-1:0] col_end;
   logic [SH-1:0] row_end;
   logic          col_fit, row_fit, col_lastwin, row_lastwin;
   logic          ciw_last, riw_last, col_wrap, row_wrap, map_wrap;

   // Register writes: zero acts as one, values above the limit saturate
   always_comb begin
      int v;
      ww_in   = ww_ff;
      wh_in   = wh_ff;
      iw_in   = iw_ff;
      ih_in   = ih_ff;
      maps_in = maps_ff;
      restart = 1'b0;
      v       = 0;
      if (csr_we) begin
         case (mpa_csr_type'(csr_index))
            CSR_WINDOW_WIDTH: begin
               v = int'(csr_wdata[4:0]);
               ww_in = WB'((v == 0) ? 1 : ((v > MAX_WINDOW) ? MAX_WINDOW : v));
               restart = 1'b1;
            end
            CSR_WINDOW_HEIGHT: begin
               v = int'(csr_wdata[4:0]);
               wh_in = WB'((v == 0) ? 1 : ((v > MAX_WINDOW) ? MAX_WINDOW : v));
               restart = 1'b1;
            end
            CSR_INPUT_WIDTH: begin
               v = int'(csr_wdata[9:0]);
               iw_in = CW'((v == 0) ? 1 : ((v > MAX_WIDTH) ? MAX_WIDTH : v));
               restart = 1'b1;
            end
            CSR_INPUT_HEIGHT: begin
               v = int'(csr_wdata[9:0]);
               ih_in = RW'((v == 0) ? 1 : ((v > MAX_HEIGHT) ? MAX_HEIGHT : v));
               restart = 1'b1;
            end
            CSR_MAP_COUNT: begin
               v = int'(csr_wdata[6:0]);
               maps_in = MW'((v == 0) ? 1 : ((v > MAX_MAPS) ? MAX_MAPS : v));
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   // A window counts only if it ends inside the map
   assign col_end     = SW'(col_start_ff) + SW'(ww_ff);
   assign row_end     = SH'(row_start_ff) + SH'(wh_ff);
   assign col_fit     = col_end <= SW'(iw_ff);
   assign row_fit     = row_end <= SH'(ih_ff);
   assign col_lastwin = (col_end + SW'(ww_ff)) > SW'(iw_ff);
   assign row_lastwin = (row_end + SH'(wh_ff)) > SH'(ih_ff);
   assign ciw_last    = ciw_ff == (ww_ff - WB'(1));
   assign riw_last    = riw_ff == (wh_ff - WB'(1));
   assign col_wrap    = col_ff == (iw_ff - CW'(1));
   assign row_wrap    = row_ff == (ih_ff - RW'(1));
   assign map_wrap    = map_ff == (maps_ff - MW'(1));

   always_comb begin
      tag.active    = col_fit && row_fit;
      tag.first     = (ciw_ff == '0) && (riw_ff == '0);
      tag.emit      = col_fit && row_fit && ciw_last && riw_last;
      tag.last      = map_wrap && row_lastwin && col_lastwin;
      tag.sample    = sample;
      tag.src_index = src_ff;
      tag.out_index = out_ff;
   end

   assign rd_addr = wc_ff;

   always_comb begin
      col_in       = col_ff;
      col_start_in = col_start_ff;
      ciw_in       = ciw_ff;
      wc_in        = wc_ff;
      row_in       = row_ff;
      row_start_in = row_start_ff;
      riw_in       = riw_ff;
      map_in       = map_ff;
      src_in       = src_ff;
      out_in       = out_ff;
      if (restart) begin
         col_in       = '0;
         col_start_in = '0;
         ciw_in       = '0;
         wc_in        = '0;
         row_in       = '0;
         row_start_in = '0;
         riw_in       = '0;
         map_in       = '0;
         src_in       = '0;
         out_in       = '0;
      end else if (accept) begin
         src_in = src_ff + INDEX_W'(1);
         if (tag.emit) begin
            out_in = out_ff + INDEX_W'(1);
         end
         if (col_wrap) begin
            col_in       = '0;
            col_start_in = '0;
            ciw_in       = '0;
            wc_in        = '0;
            if (row_wrap) begin
               row_in       = '0;
               row_start_in = '0;
               riw_in       = '0;
               // end of frame: start over from the first map
               if (map_wrap) begin
                  map_in = '0;
                  src_in = '0;
                  out_in = '0;
               end else begin
                  map_in = map_ff + MW'(1);
               end
            end else begin
               row_in = row_ff + RW'(1);
               if (riw_last) begin
                  riw_in       = '0;
                  row_start_in = RW'(row_end);
               end else begin
                  riw_in = riw_ff + WB'(1);
               end
            end
         end else begin
            col_in = col_ff + CW'(1);
            if (ciw_last) begin
               ciw_in       = '0;
               col_start_in = CW'(col_end);
               wc_in        = wc_ff + AW'(1);
            end else begin
               ciw_in = ciw_ff + WB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ww_ff        <= WB'(WW_RST);
         wh_ff        <= WB'(WW_RST);
         iw_ff        <= CW'(IW_RST);
         ih_ff        <= RW'(IH_RST);
         maps_ff      <= MW'(1);
         col_ff       <= '0;
         col_start_ff <= '0;
         ciw_ff       <= '0;
         wc_ff        <= '0;
         row_ff       <= '0;
         row_start_ff <= '0;
         riw_ff       <= '0;
         map_ff       <= '0;
         src_ff       <= '0;
         out_ff       <= '0;
      end else begin
         ww_ff        <= ww_in;
         wh_ff        <= wh_in;
         iw_ff        <= iw_in;
         ih_ff        <= ih_in;
         maps_ff      <= maps_in;
         col_ff       <= col_in;
         col_start_ff <= col_start_in;
         ciw_ff       <= ciw_in;
         wc_ff        <= wc_in;
         row_ff       <= row_in;
         row_start_ff <= row_start_in;
         riw_ff       <= riw_in;
         map_ff       <= map_in;
         src_ff       <= src_in;
         out_ff       <= out_in;
      end
   end

endmodule

@@ design/mpa_update.sv @@
// Partial maximum row buffer with read, compare and write-back
module mpa_update import mpa_pkg::*; #(
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [AW-1:0]  rd_addr,
   input  mpa_tag_type    tag,
   output logic           push,
   output mpa_result_type push_data
);

   mpa_entry_type mem [MAX_WIDTH];

   mpa_entry_type rd_data_ff;
   logic          s1_valid_ff;
   mpa_tag_type   s1_tag_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          fwd_hit_ff;
   mpa_entry_type fwd_ff;

   mpa_entry_type operand, new_entry;
   logic          wr_en;

   // The write at the read's own edge is missed by the array: forward it
   assign operand = fwd_hit_ff ? fwd_ff : rd_data_ff;
   assign wr_en   = s1_valid_ff && s1_tag_ff.active;

   always_comb begin
      if (s1_tag_ff.first || ($signed(s1_tag_ff.sample) > $signed(operand.value))) begin
         new_entry.value = s1_tag_ff.sample;
         new_entry.index = s1_tag_ff.src_index;
      end else begin
         new_entry = operand;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[s1_addr_ff] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            fwd_hit_ff <= wr_en && (s1_addr_ff == rd_addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_tag_ff  <= tag;
         s1_addr_ff <= rd_addr;
         fwd_ff     <= new_entry;
      end
   end

   assign push = s1_valid_ff && s1_tag_ff.emit;

   always_comb begin
      push_data.max_value    = new_entry.value;
      push_data.source_index = new_entry.index;
      push_data.out_index    = s1_tag_ff.out_index;
      push_data.frame_last   = s1_tag_ff.last;
   end

endmodule

@@ design/mpa_outq.sv @@
// Result queue that decouples the response side from the sample stream
module mpa_outq import mpa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mpa_result_type push_data,
   output logic           space,
   mpa_rsp_if.source      rsp_ch
);

   mpa_result_type         q_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_PTR_W-1:0]  count_ff, count_in;
   logic                   pop;

   assign pop = rsp_ch.valid && rsp_ch.ready;

   // Reserve a slot for the beat still in the update stage
   assign space = ({1'b0, count_ff} + {{OUTQ_PTR_W{1'b0}}, push})
                  < (OUTQ_PTR_W + 1)'(OUTQ_DEPTH);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                     : wr_ptr_ff + OUTQ_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                     : rd_ptr_ff + OUTQ_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + OUTQ_PTR_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - OUTQ_PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_ch.valid        = count_ff != '0;
   assign rsp_ch.max_value    = q_ff[rd_ptr_ff].max_value;
   assign rsp_ch.source_index = q_ff[rd_ptr_ff].source_index;
   assign rsp_ch.out_index    = q_ff[rd_ptr_ff].out_index;
   assign rsp_ch.frame_last   = q_ff[rd_ptr_ff].frame_last;

endmodule

@@ design/mpa_checker.sv @@
// Port-level checks of the max pooling unit and their binding
`include "assert_macros.svh"

module mpa_checker import mpa_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   csr_we,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [INDEX_W-1:0]     rsp_out_index,
   input logic                   rsp_frame_last
);

   logic [INDEX_W-1:0] expect_ff;
   logic               rsp_beat;
   logic               rsp_stall;

   assign rsp_beat  = rsp_valid && rsp_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // Track the pooled index the next beat must carry; only real registers restart
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff <= '0;
      end else if (csr_we && (csr_index inside {[CSR_WINDOW_WIDTH:CSR_MAP_COUNT]})) begin
         expect_ff <= '0;
      end else if (rsp_beat) begin
         expect_ff <= rsp_frame_last ? '0 : rsp_out_index + INDEX_W'(1);
      end
   end

   `MPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_out_index))
   `MPA_ASSERT_NOW(a_out_index_seq, clock, reset, rsp_beat, rsp_out_index == expect_ff)
   `MPA_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind max_pool_with_argmax_unit mpa_checker u_mpa_checker (
   .clock          (clock),
   .reset          (reset),
   .csr_we         (csr_we),
   .csr_index      (csr_index),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_out_index  (rsp_ch.out_index),
   .rsp_frame_last (rsp_ch.frame_last)
);

@@ bench/max_pool_with_argmax_unit_tb.sv @@
// Self-checking bench for the max pooling unit: directed rows, random frames, argmax scoreboard
module max_pool_with_argmax_unit_tb import mpa_pkg::*; ();

   localparam int          HALF_PERIOD     = 5;
   localparam int          RESET_CYCLES    = 8;
   localparam int          SETTLE_CYCLES   = 4;
   localparam int          DRAIN_CYCLES    = 12;
   localparam int unsigned RANDOM_ITEMS    = 1550;
   localparam int unsigned EXTREME_COUNT   = 5;
   localparam longint      LIMIT_CYCLES    = 1000000;
   localparam int          REPORT_LIMIT    = 10;

   localparam logic [CSR_INDEX_W-1:0]  CSR_SPARE_INDEX = 3'd5;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef struct {
      bit                         is_write;
      logic [CSR_INDEX_W-1:0]     reg_index;
      logic [CSR_DATA_W-1:0]      reg_data;
      logic signed [SAMPLE_W-1:0] sample;
      bit                         fixed;
      bit                         fixed_hit;
      mpa_result_type             fixed_res;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   mpa_req_if req_bus ();
   mpa_rsp_if rsp_bus ();

   max_pool_with_argmax_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Pooling predictor: register copies, row of partial maxima, frame counters
   logic [4:0]                 pool_ww, pool_wh;
   logic [9:0]                 pool_iw, pool_ih;
   logic [6:0]                 pool_maps;
   logic signed [SAMPLE_W-1:0] col_max_value [DEF_MAX_WIDTH];
   logic [INDEX_W-1:0]         col_max_index [DEF_MAX_WIDTH];
   int unsigned                col_pos, row_pos, map_pos, col_in_win, row_in_win;
   logic [INDEX_W-1:0]         src_count, out_count;

   mpa_result_type pool_expect [$];
   stim_row_type   directed_rows [$];
   int             faults = 0;
   int unsigned    samples_sent = 0;
   int unsigned    ready_hold = 0;
   bit             sink_calm = 1'b0;

   function automatic int unsigned clamp_field(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic void restart_frame();
      col_pos = 0;
      row_pos = 0;
      map_pos = 0;
      col_in_win = 0;
      row_in_win = 0;
      src_count = '0;
      out_count = '0;
   endfunction

   function automatic void note_register(logic [CSR_INDEX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_WINDOW_WIDTH:  pool_ww = data[4:0];
         CSR_WINDOW_HEIGHT: pool_wh = data[4:0];
         CSR_INPUT_WIDTH:   pool_iw = data[9:0];
         CSR_INPUT_HEIGHT:  pool_ih = data[9:0];
         CSR_MAP_COUNT:     pool_maps = data[6:0];
         default:           return;
      endcase
      restart_frame();
   endfunction

   function automatic bit pool_step(logic signed [SAMPLE_W-1:0] s,
                                    output mpa_result_type r);
      int unsigned ww, wh, iw, ih, maps, wout, hout, wc;
      bit hit;
      ww = clamp_field(pool_ww, DEF_MAX_WINDOW);
      wh = clamp_field(pool_wh, DEF_MAX_WINDOW);
      iw = clamp_field(pool_iw, DEF_MAX_WIDTH);
      ih = clamp_field(pool_ih, DEF_MAX_HEIGHT);
      maps = clamp_field(pool_maps, DEF_MAX_MAPS);
      wout = iw / ww;
      hout = ih / wh;
      hit = 1'b0;
      r = '0;
      // trailing columns and rows outside whole windows are swallowed
      if (col_pos < wout * ww && row_pos < hout * wh) begin
         wc = col_pos / ww;
         if ((col_in_win == 0 && row_in_win == 0) || s > col_max_value[wc]) begin
            col_max_value[wc] = s;
            col_max_index[wc] = src_count;
         end
         if (col_in_win == ww - 1 && row_in_win == wh - 1) begin
            r.max_value = col_max_value[wc];
            r.source_index = col_max_index[wc];
            r.out_index = out_count;
            r.frame_last = (map_pos == maps - 1) && (row_pos / wh == hout - 1) &&
                           (wc == wout - 1);
            out_count = out_count + 1'b1;
            hit = 1'b1;
         end
      end
      src_count = src_count + 1'b1;
      col_pos++;
      col_in_win++;
      if (col_in_win >= ww) col_in_win = 0;
      if (col_pos >= iw) begin
         col_pos = 0;
         col_in_win = 0;
         row_pos++;
         row_in_win++;
         if (row_in_win >= wh) row_in_win = 0;
         if (row_pos >= ih) begin
            row_pos = 0;
            row_in_win = 0;
            map_pos++;
            if (map_pos >= maps) restart_frame();
         end
      end
      return hit;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0, 1, 2: return SAMPLE_W'($urandom);
         3:       return ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
         default: return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
      endcase
   endfunction

   function automatic void add_write(logic [CSR_INDEX_W-1:0] idx,
                                     logic [CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{default: '0};
      row.is_write = 1'b1;
      row.reg_index = idx;
      row.reg_data = data;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_sample(logic signed [SAMPLE_W-1:0] s);
      stim_row_type row;
      row = '{default: '0};
      row.sample = s;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_known(logic signed [SAMPLE_W-1:0] s, bit hit,
                                     logic signed [SAMPLE_W-1:0] value,
                                     logic [INDEX_W-1:0] src, logic [INDEX_W-1:0] oidx,
                                     logic last);
      stim_row_type row;
      row = '{default: '0};
      row.sample = s;
      row.fixed = 1'b1;
      row.fixed_hit = hit;
      row.fixed_res = '{max_value: value, source_index: src, out_index: oidx,
                        frame_last: last};
      directed_rows.push_back(row);
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input int unsigned gap,
                              input bit fixed, input bit fixed_hit,
                              input mpa_result_type fixed_res);
      mpa_result_type r;
      bit hit;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.sample <= s;
      do @(posedge clock); while (!req_bus.ready);
      hit = pool_step(s, r);
      if (fixed) begin
         hit = fixed_hit;
         r = fixed_res;
      end
      if (hit) pool_expect.push_back(r);
      samples_sent++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pool_expect.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      req_bus.valid <= 1'b0;
      wait_drained();
      // beats that produce no result may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      note_register(idx, data);
   endtask

   task automatic program_pool(input int unsigned ww, wh, iw, ih, maps);
      logic [CSR_DATA_W-1:0] noise;
      // junk above a narrow register's width must be dropped by the block
      noise = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom) : '0;
      write_reg(CSR_WINDOW_WIDTH, (noise & 10'h3E0) | CSR_DATA_W'(ww));
      write_reg(CSR_WINDOW_HEIGHT, (noise & 10'h3E0) | CSR_DATA_W'(wh));
      write_reg(CSR_INPUT_WIDTH, CSR_DATA_W'(iw));
      write_reg(CSR_INPUT_HEIGHT, CSR_DATA_W'(ih));
      write_reg(CSR_MAP_COUNT, (noise & 10'h380) | CSR_DATA_W'(maps));
   endtask

   task automatic run_phase(input bit extreme, input int unsigned pick, input bit force_pause);
      int unsigned ww, wh, iw, ih, maps, frame, total, pause_at, k;
      bit calm;
      if (extreme) begin
         case (pick)
            0:       begin ww = 31; wh = 1;  iw = 1023; ih = 1;   maps = 1;   end
            1:       begin ww = 1;  wh = 16; iw = 1;    ih = 512; maps = 1;   end
            2:       begin ww = 1;  wh = 1;  iw = 1;    ih = 1;   maps = 127; end
            3:       begin ww = 8;  wh = 3;  iw = 5;    ih = 3;   maps = 2;   end
            default: begin ww = 0;  wh = 0;  iw = 3;    ih = 2;   maps = 0;   end
         endcase
      end else begin
         ww = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         wh = $urandom_range(1, 4);
         iw = ww * $urandom_range(1, 3) + $urandom_range(0, 2);
         ih = wh * $urandom_range(1, 2) + $urandom_range(0, 1);
         maps = $urandom_range(1, 2);
      end
      program_pool(ww, wh, iw, ih, maps);
      frame = clamp_field(iw, DEF_MAX_WIDTH) * clamp_field(ih, DEF_MAX_HEIGHT) *
              clamp_field(maps & 7'h7F, DEF_MAX_MAPS);
      total = extreme ? frame : frame * $urandom_range(1, 2);
      // leave a broken frame behind now and then; the next write restarts it
      if (!extreme && $urandom_range(0, 2) == 0) total += $urandom_range(1, frame);
      calm = ($urandom_range(0, 3) == 0);
      sink_calm = calm;
      pause_at = (force_pause || $urandom_range(0, 3) == 0) ? $urandom_range(1, total) : 0;
      for (k = 1; k <= total; k++) begin
         if (k == pause_at) begin
            req_bus.valid <= 1'b0;
            wait_drained();
         end
         send_sample(random_sample(), calm ? 0 : pick_gap(), 1'b0, 1'b0, '0);
      end
      sink_calm = 1'b0;
   endtask

   // Response side: random stalls, with calm stretches
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold <= pick_gap();
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_hold <= $urandom_range(0, 5);
      end
   end

   always @(posedge clock) begin : watch_pool
      mpa_result_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{max_value: rsp_bus.max_value, source_index: rsp_bus.source_index,
                 out_index: rsp_bus.out_index, frame_last: rsp_bus.frame_last};
         if (pool_expect.size() == 0) begin
            if (faults < REPORT_LIMIT)
               $display("unexpected pooled beat: value %0d src %0d out %0d last %0b",
                        got.max_value, got.source_index, got.out_index, got.frame_last);
            faults++;
         end else begin
            want = pool_expect.pop_front();
            if (got.max_value !== want.max_value || got.source_index !== want.source_index ||
                got.out_index !== want.out_index || got.frame_last !== want.frame_last) begin
               if (faults < REPORT_LIMIT)
                  $display("pooled beat mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                           want.max_value, want.source_index, want.out_index,
                           want.frame_last, got.max_value, got.source_index,
                           got.out_index, got.frame_last);
               faults++;
            end
         end
      end
   end

   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("** max_pool_with_argmax_unit: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int unsigned idx, directed_count, phase, next_extreme;
      bit extreme_turn;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.sample <= '0;
      pool_ww = 5'd2;
      pool_wh = 5'd2;
      pool_iw = 10'd32;
      pool_ih = 10'd32;
      pool_maps = 7'd1;
      restart_frame();

      // 2x2 windows and one map from reset; tied maxima keep the earlier beat,
      // and an all-minimum window still takes its first sample
      add_write(CSR_INPUT_WIDTH, 10'd4);
      add_write(CSR_INPUT_HEIGHT, 10'd2);
      add_known(SAMPLE_MAX, 1'b0, '0, '0, '0, 1'b0);
      add_known(SAMPLE_MIN, 1'b0, '0, '0, '0, 1'b0);
      add_known(SAMPLE_MIN, 1'b0, '0, '0, '0, 1'b0);
      add_known(SAMPLE_MIN, 1'b0, '0, '0, '0, 1'b0);
      add_known(SAMPLE_MIN, 1'b0, '0, '0, '0, 1'b0);
      add_known(SAMPLE_MAX, 1'b1, SAMPLE_MAX, 24'd0, 24'd0, 1'b0);
      add_known(SAMPLE_MIN, 1'b0, '0, '0, '0, 1'b0);
      add_known(SAMPLE_MIN, 1'b1, SAMPLE_MIN, 24'd2, 24'd1, 1'b1);
      // 2x1 windows on five columns, two maps: trailing column dropped;
      // a write to an unused index must not restart the frame
      add_write(CSR_WINDOW_HEIGHT, 10'd1);
      add_write(CSR_INPUT_WIDTH, 10'd5);
      add_write(CSR_INPUT_HEIGHT, 10'd1);
      add_write(CSR_MAP_COUNT, 10'd2);
      add_sample(16'sd3);
      add_sample(-16'sd2);
      add_sample(16'sd100);
      add_write(CSR_SPARE_INDEX, 10'd1);
      add_sample(16'sd100);
      add_sample(SAMPLE_MAX);
      add_sample(-16'sd1);
      add_sample(16'sd0);
      add_sample(16'sh1234);
      add_sample(16'sh1234);
      add_sample(SAMPLE_MIN);
      // window wider than the map: beats consumed, nothing pooled
      add_write(CSR_WINDOW_WIDTH, 10'd16);
      add_known(16'sd1, 1'b0, '0, '0, '0, 1'b0);
      add_known(SAMPLE_MAX, 1'b0, '0, '0, '0, 1'b0);
      add_known(16'sd1, 1'b0, '0, '0, '0, 1'b0);
      // zero in every register acts as one: each beat is a whole frame
      add_write(CSR_WINDOW_WIDTH, 10'd0);
      add_write(CSR_WINDOW_HEIGHT, 10'd0);
      add_write(CSR_INPUT_WIDTH, 10'd0);
      add_write(CSR_INPUT_HEIGHT, 10'd0);
      add_write(CSR_MAP_COUNT, 10'd0);
      add_known(16'sh4000, 1'b1, 16'sh4000, 24'd0, 24'd0, 1'b1);
      add_known(-16'sd1, 1'b1, -16'sd1, 24'd0, 24'd0, 1'b1);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (idx = 0; idx < directed_rows.size(); idx++) begin
         if (directed_rows[idx].is_write)
            write_reg(directed_rows[idx].reg_index, directed_rows[idx].reg_data);
         else
            send_sample(directed_rows[idx].sample, pick_gap(), directed_rows[idx].fixed,
                        directed_rows[idx].fixed_hit, directed_rows[idx].fixed_res);
      end
      directed_count = samples_sent;

      // alternate ordinary frames with the extreme settings until both run out
      phase = 0;
      next_extreme = 0;
      while (samples_sent - directed_count < RANDOM_ITEMS || next_extreme < EXTREME_COUNT) begin
         extreme_turn = (phase % 2 == 1) && (next_extreme < EXTREME_COUNT);
         run_phase(extreme_turn, next_extreme, phase == 0);
         if (extreme_turn) next_extreme++;
         phase++;
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faults == 0)
         $display("** max_pool_with_argmax_unit: PASSED **");
      else
         $display("** max_pool_with_argmax_unit: FAILED **");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+design
design/mpa_pkg.sv
design/mpa_if.sv
design/mpa_ctrl.sv
design/mpa_update.sv
design/mpa_outq.sv
design/max_pool_with_argmax_unit.sv
design/mpa_checker.sv
bench/max_pool_with_argmax_unit_tb.sv
